>>> src/midi_note_event_parser_defines.svh
// Assertion macros shared by the MIDI note event parser RTL.
// Depends on nothing; expects signals named clock and reset where used.
`ifndef MIDI_NOTE_EVENT_PARSER_DEFINES_SVH
`define MIDI_NOTE_EVENT_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MNEP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mnep: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MNEP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mnep: next-cycle check failed");

`endif

>>> src/mnep_pkg.sv
// Shared types and constants of the MIDI note event parser.
// No dependencies; used by the channel interfaces, the parser core and the top level.
package mnep_pkg;

   // MIDI byte codes
   localparam logic [7:0] RT_FIRST    = 8'hF8;
   localparam logic [7:0] SYS_EX_ON   = 8'hF0;
   localparam logic [7:0] SYS_EX_OFF  = 8'hF7;
   localparam logic [7:0] DATA_MAX    = 8'h7F;
   localparam logic [3:0] NOTE_OFF_NIB    = 4'h8;
   localparam logic [3:0] NOTE_ON_NIB     = 4'h9;
   localparam logic [3:0] MSG_PROG_CHANGE = 4'hC;
   localparam logic [3:0] MSG_CHAN_PRESS  = 4'hD;

   localparam int BYTE_W  = 8;
   localparam int CHAN_W  = 4;
   localparam int DATA_W  = 7;
   localparam int LEN_W   = 2;

   // Configuration register indexes
   typedef enum logic {
      CSR_FIRST_CHANNEL  = 1'b0,
      CSR_SECOND_CHANNEL = 1'b1
   } csr_index_type;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [DATA_W-1:0] data_type;

   // One note event as delivered on the result channel
   typedef struct packed {
      logic     event_kind;
      chan_type event_channel;
      logic     assigner_index;
      data_type note_key;
      data_type note_velocity;
   } event_type;

endpackage

>>> src/mnep_ifs.sv
// Valid/ready channel interfaces of the MIDI note event parser.
// Depends on mnep_pkg for field types.

// Byte channel: one received MIDI byte per transaction
interface mnep_req_if;
   logic               valid;
   logic               ready;
   mnep_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Event channel: one note event per transaction
interface mnep_rsp_if;
   logic               valid;
   logic               ready;
   logic               event_kind;
   mnep_pkg::chan_type event_channel;
   logic               assigner_index;
   mnep_pkg::data_type note_key;
   mnep_pkg::data_type note_velocity;

   modport source (output valid, output event_kind, output event_channel,
                   output assigner_index, output note_key, output note_velocity,
                   input ready);
   modport sink (input valid, input event_kind, input event_channel,
                 input assigner_index, input note_key, input note_velocity,
                 output ready);
endinterface

>>> src/mnep_parse.sv
// Running status tracker and note decoder of the MIDI note event parser.
// Depends on mnep_pkg; consumes one byte per cycle in which step is high.
module mnep_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mnep_pkg::byte_type  rx_byte,
   input  mnep_pkg::chan_type  first_channel,
   input  mnep_pkg::chan_type  second_channel,
   output logic                emit,
   output mnep_pkg::event_type evt
);
   import mnep_pkg::*;

   byte_type           status_ff, status_in;
   data_type           first_ff, first_in;
   logic               count_ff, count_in;
   logic [LEN_W-1:0]   exp_len_ff, exp_len_in;

   logic [3:0]         msg;
   chan_type           chan;
   logic               hit;
   data_type           key;

   assign msg  = status_ff[7:4];
   assign chan = status_ff[3:0];
   assign hit  = (chan == first_channel) || (chan == second_channel);
   assign key  = (count_ff == 1'b0) ? rx_byte[DATA_W-1:0] : first_ff;

   // Decode one byte against the running status
   always_comb begin
      status_in  = status_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      exp_len_in = exp_len_ff;
      emit       = 1'b0;
      if (rx_byte >= RT_FIRST) begin
         // real-time byte: ignore
      end else if (status_ff == SYS_EX_ON) begin
         if (rx_byte == SYS_EX_OFF) begin
            status_in = SYS_EX_OFF;
         end
      end else if (rx_byte >= SYS_EX_ON) begin
         status_in = rx_byte;
      end else if (rx_byte > DATA_MAX) begin
         status_in  = rx_byte;
         count_in   = 1'b0;
         exp_len_in = ((rx_byte[7:4] == MSG_PROG_CHANGE) || (rx_byte[7:4] == MSG_CHAN_PRESS))
                      ? LEN_W'(1) : LEN_W'(2);
      end else if (exp_len_ff != '0) begin
         if (count_ff == 1'b0) begin
            first_in = rx_byte[DATA_W-1:0];
         end
         if (({1'b0, count_ff} + LEN_W'(1)) < exp_len_ff) begin
            count_in = 1'b1;
         end else begin
            count_in = 1'b0;
            emit = (status_ff < SYS_EX_ON) && hit
                   && ((msg == NOTE_OFF_NIB) || (msg == NOTE_ON_NIB));
         end
      end
   end

   // Build the event fields
   always_comb begin
      evt.event_kind     = (msg == NOTE_ON_NIB);
      evt.event_channel  = chan;
      evt.assigner_index = (chan != first_channel);
      evt.note_key       = key;
      evt.note_velocity  = (msg == NOTE_ON_NIB) ? rx_byte[DATA_W-1:0] : '0;
   end

   // Advance parser state on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         first_ff   <= '0;
         count_ff   <= 1'b0;
         exp_len_ff <= '0;
      end else if (step) begin
         status_ff  <= status_in;
         first_ff   <= first_in;
         count_ff   <= count_in;
         exp_len_ff <= exp_len_in;
      end
   end

endmodule

>>> src/midi_note_event_parser.sv
// MIDI note event parser: byte channel in, note event channel out.
// Depends on mnep_pkg, mnep_ifs, mnep_parse and midi_note_event_parser_defines.svh.
//
// Usage: feed received MIDI bytes on req_if, one byte per transaction. The
// block tracks running status, skips system exclusive and real-time bytes,
// and emits one rsp_if transaction for each completed note on or note off
// on first_channel or second_channel. Other bytes produce no transaction.
// Channels are set through the csr_ write port, by the user only while the
// block is idle; the block itself does not enforce this. An event passes
// through the input register, then the event register, before it is
// presented on rsp_if. Throughput: one byte per cycle, sustained while
// rsp_if takes events; the parser core decodes each byte combinationally
// between the input register and the event register.
// When rsp_if.ready is low with an event pending, the event register holds
// and bytes stop at the input register; req_if.ready drops only once that
// register is also full. Synchronous reset clears both valid flags, the
// running status and the channel registers (both to channel 0).
module midi_note_event_parser (
   input  logic                   clock,
   input  logic                   reset,
   mnep_req_if.sink               req_if,
   mnep_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  mnep_pkg::csr_index_type csr_index,
   input  mnep_pkg::chan_type     csr_wr_data
);
   import mnep_pkg::*;
`include "midi_note_event_parser_defines.svh"

   logic      in_valid_ff;
   byte_type  in_byte_ff;
   logic      out_valid_ff, out_valid_in;
   event_type out_evt_ff;
   chan_type  first_ch_ff, second_ch_ff;

   logic      advance;
   logic      emit;
   event_type evt;

   // Move the held byte into the parser when the event register can take a result
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Capture channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ch_ff  <= '0;
         second_ch_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_CHANNEL:  first_ch_ff  <= csr_wr_data;
            CSR_SECOND_CHANNEL: second_ch_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Hold one incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   mnep_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .first_channel  (first_ch_ff),
      .second_channel (second_ch_ff),
      .emit           (emit),
      .evt            (evt)
   );

   // Load or drain the event register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_evt_ff <= evt;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.event_kind     = out_evt_ff.event_kind;
   assign rsp_if.event_channel  = out_evt_ff.event_channel;
   assign rsp_if.assigner_index = out_evt_ff.assigner_index;
   assign rsp_if.note_key       = out_evt_ff.note_key;
   assign rsp_if.note_velocity  = out_evt_ff.note_velocity;

   // Checks
   `MNEP_ASSERT_NEXT(a_emit_loads, advance && emit, out_valid_ff)
   `MNEP_ASSERT_SAME(a_off_no_vel, out_valid_ff && !out_evt_ff.event_kind, out_evt_ff.note_velocity == '0)
   `MNEP_ASSERT_SAME(a_empty_ready, !in_valid_ff, req_if.ready)

endmodule
